// ----- rtl/imeng_pkg.sv -----
// Shared types, codes and default sizes for the integer matrix engine.
package imeng_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;
  // Widest operand that the shared multiplier takes in one pass.
  localparam int MUL_W          = 32;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  // Operation register codes.
  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_TRN = 3'd3,
    OP_TRC = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_COLS_A    = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_OPERATION = 2'd3
  } reg_idx_t;

  // One input beat.
  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
    logic               error;
  } result_t;

  // Control from the sequencer to the shared arithmetic unit.
  typedef struct packed {
    logic       load;     // capture operands and product into the term register
    logic       accum;    // update the accumulator from the term register
    logic       mul;      // term is a partial product
    logic       use_lhs;  // element-wise add or subtract: base is the A operand
    logic       neg;      // subtract the term
    logic       first;    // first term of an element: accumulator starts at zero
    logic [1:0] ph;       // partial-product phase for wide words
  } alu_ctl_t;

  // Result framing from the sequencer.
  typedef struct packed {
    logic       valid;
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
    logic       error;
  } res_ctl_t;

endpackage

// ----- rtl/imeng_ram.sv -----
// Single-write, single-read element store with registered read data.
module imeng_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/imeng_alu.sv -----
// Shared multiply and add unit with the term register and the accumulator.
module imeng_alu
  import imeng_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  alu_ctl_t              ctl,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic [DATA_WIDTH-1:0] acc
);

  localparam int HW = (DATA_WIDTH > MUL_W) ? MUL_W : DATA_WIDTH;

  logic [HW-1:0]         a_lo, a_hi, b_lo, b_hi;
  logic [HW-1:0]         mx, my;
  logic [2*HW-1:0]       prod;
  logic [DATA_WIDTH-1:0] pp;
  logic [DATA_WIDTH-1:0] term;
  logic [DATA_WIDTH-1:0] lhs;
  logic [DATA_WIDTH-1:0] base;
  logic [DATA_WIDTH-1:0] addend;

  // Split wide words into halves; phase 0 is low by low, 1 high by low, 2 low by high.
  always_comb begin
    a_lo = HW'(a);
    a_hi = HW'(a >> HW);
    b_lo = HW'(b);
    b_hi = HW'(b >> HW);
    mx   = (ctl.ph == 2'd1) ? a_hi : a_lo;
    my   = (ctl.ph == 2'd2) ? b_hi : b_lo;
    prod = (2*HW)'(mx) * (2*HW)'(my);
    pp   = (ctl.ph == 2'd0) ? DATA_WIDTH'(prod) : (DATA_WIDTH'(prod) << HW);
  end

  // Term register sits after the multiplier.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.mul) begin
        term <= pp;
      end else if (ctl.use_lhs) begin
        term <= b;
      end else begin
        term <= a;
      end
      lhs <= a;
    end
  end

  // One adder: base plus term, or base minus term.
  always_comb begin
    if (ctl.use_lhs) begin
      base = lhs;
    end else if (ctl.first) begin
      base = '0;
    end else begin
      base = acc;
    end
    addend = ctl.neg ? ~term : term;
  end

  always_ff @(posedge clk) begin
    if (ctl.accum) begin
      acc <= base + addend + DATA_WIDTH'(ctl.neg);
    end
  end

endmodule

// ----- rtl/imeng_seq.sv -----
// Sequencer: configuration registers, load decode and the element walk.
module imeng_seq
  import imeng_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ADDR_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  item_t                 item,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_data,
  output logic                  busy,
  output logic                  a_we,
  output logic                  b_we,
  output logic [ADDR_W-1:0]     waddr,
  output logic [DATA_WIDTH-1:0] wdata,
  output logic [ADDR_W-1:0]     a_raddr,
  output logic [ADDR_W-1:0]     b_raddr,
  output alu_ctl_t              alu_ctl,
  output res_ctl_t              res
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;
  localparam int NPH   = (DATA_WIDTH > MUL_W) ? 3 : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_OPER, S_ACC} state_t;

  state_t           state;
  logic [3:0]       rows_a, cols_a, cols_b;
  logic [2:0]       operation;
  logic [DIM_W-1:0] orow, ocol, k;
  logic [1:0]       ph;
  logic [CNT_W-1:0] ra, ca, cb;
  logic [CNT_W-1:0] lim_r, lim_c, lim_k;
  logic [CNT_W-1:0] br, bc;
  logic             is_mul;
  logic             accepted;
  logic             ph_last, term_done, row_last, col_last;
  logic             a_in, b_in;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [3:0] v);
    logic [CNT_W-1:0] r;
    if (v == 4'd0) begin
      r = CNT_W'(1);
    end else if ({1'b0, v} > 5'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] r,
                                                input logic [ADDR_W-1:0] c);
    return ADDR_W'(r * ADDR_W'(MAX_DIM) + c);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= 4'd1;
      cols_a    <= 4'd1;
      cols_b    <= 4'd1;
      operation <= OP_MUL;
    end else if (cfg_valid && !busy) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_COLS_A:    cols_a    <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        REG_OPERATION: operation <= cfg_data[2:0];
        default:       ;
      endcase
    end
  end

  // Effective dimensions and loop limits of the configured operation.
  always_comb begin
    ra     = clamp_dim(rows_a);
    ca     = clamp_dim(cols_a);
    cb     = clamp_dim(cols_b);
    is_mul = (operation == OP_MUL);
    br     = is_mul ? ca : ra;
    bc     = is_mul ? cb : ca;
    case (operation)
      OP_MUL: begin
        lim_r = ra;
        lim_c = cb;
        lim_k = ca;
      end
      OP_ADD, OP_SUB: begin
        lim_r = ra;
        lim_c = ca;
        lim_k = CNT_W'(1);
      end
      OP_TRN: begin
        lim_r = ca;
        lim_c = ra;
        lim_k = CNT_W'(1);
      end
      OP_TRC: begin
        lim_r = CNT_W'(1);
        lim_c = CNT_W'(1);
        lim_k = ra;
      end
      default: begin
        lim_r = CNT_W'(1);
        lim_c = CNT_W'(1);
        lim_k = CNT_W'(1);
      end
    endcase
    ph_last   = !is_mul || (ph == 2'(NPH - 1));
    term_done = ph_last && (CNT_W'(k) + CNT_W'(1) == lim_k);
    row_last  = (CNT_W'(orow) + CNT_W'(1) == lim_r);
    col_last  = (CNT_W'(ocol) + CNT_W'(1) == lim_c);
  end

  // Load decode: writes that fall inside the current shape reach the stores.
  assign accepted = start && !busy;
  assign a_in     = (CMP_W'(item.row) < CMP_W'(ra)) && (CMP_W'(item.col) < CMP_W'(ca));
  assign b_in     = (CMP_W'(item.row) < CMP_W'(br)) && (CMP_W'(item.col) < CMP_W'(bc));
  assign a_we     = accepted && (item.command == CMD_LOAD_A) && a_in;
  assign b_we     = accepted && (item.command == CMD_LOAD_B) && b_in;
  assign waddr    = addr_of(ADDR_W'(item.row), ADDR_W'(item.col));
  assign wdata    = DATA_WIDTH'(item.value);

  // Read addresses follow the walk counters.
  always_comb begin
    case (operation)
      OP_MUL: begin
        a_raddr = addr_of(ADDR_W'(orow), ADDR_W'(k));
        b_raddr = addr_of(ADDR_W'(k), ADDR_W'(ocol));
      end
      OP_TRN: begin
        a_raddr = addr_of(ADDR_W'(ocol), ADDR_W'(orow));
        b_raddr = addr_of(ADDR_W'(ocol), ADDR_W'(orow));
      end
      OP_TRC: begin
        a_raddr = addr_of(ADDR_W'(k), ADDR_W'(k));
        b_raddr = addr_of(ADDR_W'(k), ADDR_W'(k));
      end
      default: begin
        a_raddr = addr_of(ADDR_W'(orow), ADDR_W'(ocol));
        b_raddr = addr_of(ADDR_W'(orow), ADDR_W'(ocol));
      end
    endcase
  end

  // Control for the shared unit.
  always_comb begin
    alu_ctl.load    = (state == S_OPER);
    alu_ctl.accum   = (state == S_ACC);
    alu_ctl.mul     = is_mul;
    alu_ctl.use_lhs = (operation == OP_ADD) || (operation == OP_SUB);
    alu_ctl.neg     = (operation == OP_SUB);
    alu_ctl.first   = (k == '0) && (ph == 2'd0);
    alu_ctl.ph      = ph;
  end

  assign busy = (state != S_IDLE) || res.valid;

  // Walk state machine and result framing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      orow      <= '0;
      ocol      <= '0;
      k         <= '0;
      ph        <= 2'd0;
      res       <= '0;
    end else begin
      res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          orow <= '0;
          ocol <= '0;
          k    <= '0;
          ph   <= 2'd0;
          if (accepted && (item.command == CMD_START)) begin
            if ((operation > OP_TRC) || ((operation == OP_TRC) && (ra != ca))) begin
              res.valid <= 1'b1;
              res.row   <= 3'd0;
              res.col   <= 3'd0;
              res.last  <= 1'b1;
              res.error <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_OPER;
        end
        S_OPER: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (!term_done) begin
            if (!ph_last) begin
              ph <= ph + 2'd1;
            end else begin
              ph <= 2'd0;
              k  <= k + DIM_W'(1);
            end
            state <= S_READ;
          end else begin
            res.valid <= 1'b1;
            res.row   <= 3'(orow);
            res.col   <= 3'(ocol);
            res.last  <= row_last && col_last;
            res.error <= 1'b0;
            ph        <= 2'd0;
            k         <= '0;
            if (col_last) begin
              ocol <= '0;
              if (row_last) begin
                state <= S_IDLE;
              end else begin
                orow  <= orow + DIM_W'(1);
                state <= S_READ;
              end
            end else begin
              ocol  <= ocol + DIM_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/integer_matrix_engine_unit.sv -----
// Loads are accepted only while idle; a start walks the stores term by term (read, multiply,
// accumulate in the shared unit) over the saturated sizes, building multiply terms above
// 32-bit words from the partial products low by low, high by low and low by high.
// busy stays high through the last result beat; an error result comes in the cycle after start.
// Synchronous reset clears control and registers; the stores are not cleared.
module integer_matrix_engine_unit
  import imeng_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output logic       result_valid,
  output result_t    result
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                  a_we, b_we;
  logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0] wdata, a_rdata, b_rdata, acc;
  alu_ctl_t              alu_ctl;
  res_ctl_t              res;

  imeng_seq #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .wdata     (wdata),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .alu_ctl   (alu_ctl),
    .res       (res)
  );

  imeng_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imeng_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  imeng_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .a   (a_rdata),
    .b   (b_rdata),
    .acc (acc)
  );

  // Configuration is taken whenever no run is in progress.
  assign cfg_ready = !busy;

  // Result beat: framing from the sequencer, value from the accumulator.
  always_comb begin
    result_valid     = res.valid;
    result.out_row   = res.row;
    result.out_col   = res.col;
    result.out_value = res.error ? 32'sd0 : 32'(acc);
    result.last      = res.last;
    result.error     = res.error;
  end

  // A result beat only appears while the block reports busy.
  a_beat_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result beat while not busy");

  // The last beat of a run is never followed directly by another beat.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result beat right after the last beat");

  // An error beat always closes the run.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error) |-> result.last)
    else $error("error beat without last");

  // A load never starts a run.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.command != CMD_START)) |=> !busy)
    else $error("load command made the block busy");

endmodule
